### src/asp_pkg.sv
package asp_pkg;

    localparam logic [7:0] ESC_BYTE   = 8'h1B;
    localparam logic [7:0] LBRACKET   = 8'h5B;
    localparam logic [7:0] SEMICOLON  = 8'h3B;
    localparam logic [7:0] FINAL_LO   = 8'h40;
    localparam logic [7:0] FINAL_HI   = 8'h7E;
    localparam logic [7:0] FINAL_SGR  = 8'h6D;
    localparam logic [7:0] DIGIT_0    = 8'h30;
    localparam logic [7:0] DIGIT_9    = 8'h39;

    localparam logic       REG_DEFAULT_FG = 1'b0;
    localparam logic       REG_DEFAULT_BG = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EMIT_ESC,
        ST_EMIT_CHAR,
        ST_APPLY,
        ST_WAIT
    } t_state;

    // parse mode
    typedef enum logic [1:0] {
        PM_TEXT,
        PM_ESC,
        PM_CSI
    } t_mode;

    // controller -> datapath
    typedef struct packed {
        logic load_byte;
        logic digit;
        logic end_field;
        logic open_csi;
        logic apply_start;
        logic apply_step;
        logic emit_esc;
        logic emit_char;
    } t_ctrl;

    // datapath -> controller
    typedef struct packed {
        logic apply_done;
        logic out_busy;
    } t_stat;

    // one basic color, bright lifts a zero component to 128
    function automatic logic [23:0] basic_color(input logic [2:0] code, input logic bright);
        logic [7:0] off;
        begin
            off = bright ? 8'd128 : 8'd0;
            basic_color = {code[0] ? 8'd255 : off,
                           code[1] ? 8'd255 : off,
                           code[2] ? 8'd255 : off};
        end
    endfunction

    // gray ramp level, round to nearest of g/23*255
    function automatic logic [7:0] gray_level(input logic [4:0] gy);
        begin
            case (gy)
                5'd0:    gray_level = 8'd0;
                5'd1:    gray_level = 8'd11;
                5'd2:    gray_level = 8'd22;
                5'd3:    gray_level = 8'd33;
                5'd4:    gray_level = 8'd44;
                5'd5:    gray_level = 8'd55;
                5'd6:    gray_level = 8'd67;
                5'd7:    gray_level = 8'd78;
                5'd8:    gray_level = 8'd89;
                5'd9:    gray_level = 8'd100;
                5'd10:   gray_level = 8'd111;
                5'd11:   gray_level = 8'd122;
                5'd12:   gray_level = 8'd133;
                5'd13:   gray_level = 8'd144;
                5'd14:   gray_level = 8'd155;
                5'd15:   gray_level = 8'd166;
                5'd16:   gray_level = 8'd177;
                5'd17:   gray_level = 8'd188;
                5'd18:   gray_level = 8'd200;
                5'd19:   gray_level = 8'd211;
                5'd20:   gray_level = 8'd222;
                5'd21:   gray_level = 8'd233;
                5'd22:   gray_level = 8'd244;
                default: gray_level = 8'd255;
            endcase
        end
    endfunction

    // 256 color palette entry
    function automatic logic [23:0] indexed_color(input logic [7:0] idx);
        logic [7:0]  v;
        logic [13:0] q36;
        logic [13:0] q6;
        logic [2:0]  r;
        logic [2:0]  g;
        logic [2:0]  b;
        logic [7:0]  rr;
        begin
            v   = idx - 8'd16;
            // v / 36 and rr / 6 by reciprocal multiply, exact over the cube
            q36 = 14'(v) * 14'd57;
            r   = q36[13:11];
            rr  = v - 8'(r) * 8'd36;
            q6  = 14'(rr) * 14'd43;
            g   = q6[10:8];
            b   = 3'(rr - 8'(g) * 8'd6);
            if (idx < 8'd16) begin
                indexed_color = basic_color(idx[2:0], idx[3]);
            end else if (idx < 8'd232) begin
                indexed_color = {8'(r) * 8'd51, 8'(g) * 8'd51, 8'(b) * 8'd51};
            end else begin
                indexed_color = {3{gray_level(5'(idx - 8'd232))}};
            end
        end
    endfunction

endpackage

### src/asp_ram.sv
module asp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### src/asp_ctrl.sv
module asp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [7:0]     i_byte,
    input  asp_pkg::t_stat i_stat,
    output logic           o_stall,
    output asp_pkg::t_ctrl o_ctrl
);
    import asp_pkg::*;

    t_state r_state, n_state;
    t_mode  r_mode, n_mode;
    logic   w_acc;
    logic   w_final;
    logic   w_digit;

    assign w_acc   = i_valid && !o_stall;
    assign w_final = (i_byte >= FINAL_LO) && (i_byte <= FINAL_HI);
    assign w_digit = (i_byte >= DIGIT_0) && (i_byte <= DIGIT_9);

    // next state
    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    if (r_mode == PM_CSI) begin
                        if (w_final) begin
                            n_mode  = PM_TEXT;
                            n_state = (i_byte == FINAL_SGR) ? ST_APPLY : ST_IDLE;
                        end
                    end else if (r_mode == PM_ESC) begin
                        if (i_byte == LBRACKET) begin
                            n_mode = PM_CSI;
                        end else begin
                            n_state = ST_EMIT_ESC;
                            n_mode  = (i_byte == ESC_BYTE) ? PM_ESC : PM_TEXT;
                        end
                    end else if (i_byte == ESC_BYTE) begin
                        n_mode = PM_ESC;
                    end else begin
                        n_state = ST_EMIT_CHAR;
                    end
                end
            end
            ST_EMIT_ESC: begin
                if (!i_stat.out_busy) begin
                    n_state = (r_mode == PM_ESC) ? ST_WAIT : ST_EMIT_CHAR;
                end
            end
            ST_EMIT_CHAR: begin
                if (!i_stat.out_busy) n_state = ST_WAIT;
            end
            ST_APPLY: begin
                if (i_stat.apply_done) n_state = ST_IDLE;
            end
            ST_WAIT: begin
                if (!i_stat.out_busy) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ctrl  = '0;
        o_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                o_ctrl.load_byte = w_acc;
                if (w_acc && r_mode == PM_CSI) begin
                    o_ctrl.digit       = w_digit;
                    o_ctrl.end_field   = w_final || (i_byte == SEMICOLON);
                    o_ctrl.apply_start = i_byte == FINAL_SGR;
                end
                if (w_acc && r_mode == PM_ESC && i_byte == LBRACKET) begin
                    o_ctrl.open_csi = 1'b1;
                end
            end
            ST_EMIT_ESC:  o_ctrl.emit_esc  = !i_stat.out_busy;
            ST_EMIT_CHAR: o_ctrl.emit_char = !i_stat.out_busy;
            ST_APPLY:     o_ctrl.apply_step = 1'b1;
            ST_WAIT:      o_ctrl = '0;
            default:      o_ctrl = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_mode  <= PM_TEXT;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
        end
    end
endmodule

### src/asp_datapath.sv
module asp_datapath #(
    parameter int MAX_PARAMS = 16,
    parameter int PARAM_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [7:0]     i_byte,
    input  asp_pkg::t_ctrl i_ctrl,
    input  logic           i_cfg_we,
    input  logic           i_cfg_idx,
    input  logic [23:0]    i_cfg_data,
    input  logic           i_out_stall,
    output asp_pkg::t_stat o_stat,
    output logic           o_valid,
    output logic [7:0]     o_char_code,
    output logic [7:0]     o_attributes,
    output logic [23:0]    o_fg_color,
    output logic [23:0]    o_bg_color,
    output logic           o_new_segment,
    output logic           o_last
);
    import asp_pkg::*;

    localparam int AW = $clog2(MAX_PARAMS);
    localparam int CW = $clog2(MAX_PARAMS + 1);
    localparam logic [PARAM_BITS-1:0] PMAX = '1;

    // apply walk phases
    typedef enum logic [2:0] {
        AP_CODE, AP_SEL, AP_IDX, AP_R, AP_G, AP_B
    } t_aph;

    logic [23:0] r_def_fg, r_def_bg;
    logic [PARAM_BITS-1:0] r_field, n_field;
    logic        r_fstat;
    logic [CW-1:0] r_count;
    logic [7:0]  r_flags;
    logic [23:0] r_fg, r_bg;
    logic        r_seg_open;
    logic [7:0]  r_byte;

    // apply walk
    logic [CW-1:0] r_rd;      // next address to read
    logic [CW-1:0] r_cur;     // index of the data now on the RAM output
    logic          r_prime;
    logic          r_active;
    t_aph          r_aph;
    logic          r_is_fg;
    logic [7:0]    r_cr, r_cg;
    logic [PARAM_BITS-1:0] w_p;
    logic [AW-1:0] w_raddr;

    // output register
    logic        r_ovalid;
    logic [7:0]  r_ochar;
    logic [7:0]  r_oattr;
    logic [23:0] r_ofg, r_obg;
    logic        r_oseg, r_olast;

    // field accumulate with saturation
    logic [PARAM_BITS+3:0] w_mul;
    always_comb begin
        w_mul = {r_field, 3'b0} + {3'b0, r_field, 1'b0} + (PARAM_BITS+4)'(i_byte - DIGIT_0);
        n_field = (w_mul > (PARAM_BITS+4)'(PMAX)) ? PMAX : w_mul[PARAM_BITS-1:0];
    end

    logic w_we;
    assign w_we = i_ctrl.end_field && r_fstat && (r_count < CW'(MAX_PARAMS));

    assign w_raddr = r_rd[AW-1:0];

    asp_ram #(.WIDTH(PARAM_BITS), .DEPTH(MAX_PARAMS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(r_count[AW-1:0]),
        .i_wdata(r_field),
        .i_raddr(w_raddr),
        .o_rdata(w_p)
    );

    logic [CW-1:0] w_cnt_fin;
    assign w_cnt_fin = r_count;

    logic w_sat8;
    logic [7:0] w_p8;
    assign w_sat8 = w_p > PARAM_BITS'(255);
    assign w_p8   = w_sat8 ? 8'd255 : w_p[7:0];

    logic w_emit;
    assign w_emit = i_ctrl.emit_esc || i_ctrl.emit_char;
    assign o_stat.out_busy   = r_ovalid && i_out_stall;
    assign o_stat.apply_done = r_active && !r_prime && (r_cur >= r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_def_fg   <= 24'hFFFFFF;
            r_def_bg   <= 24'h000000;
            r_field    <= '0;
            r_fstat    <= 1'b0;
            r_count    <= '0;
            r_flags    <= '0;
            r_fg       <= 24'hFFFFFF;
            r_bg       <= 24'h000000;
            r_seg_open <= 1'b0;
            r_active   <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_DEFAULT_FG) r_def_fg <= i_cfg_data;
                else                             r_def_bg <= i_cfg_data;
            end
            if (i_ctrl.load_byte) r_byte <= i_byte;
            if (i_ctrl.open_csi) begin
                r_field <= '0;
                r_fstat <= 1'b0;
                r_count <= '0;
            end
            if (i_ctrl.digit) begin
                r_field <= n_field;
                r_fstat <= 1'b1;
            end
            if (i_ctrl.end_field) begin
                if (w_we) r_count <= r_count + 1'b1;
                r_field <= '0;
                r_fstat <= 1'b0;
                r_seg_open <= !(i_byte >= FINAL_LO && i_byte <= FINAL_HI) && r_seg_open;
            end

            // start the walk
            if (i_ctrl.apply_start) begin
                r_active <= 1'b1;
                r_prime  <= 1'b1;
                r_rd     <= '0;
                r_cur    <= '0;
                r_aph    <= AP_CODE;
            end
            if (i_ctrl.apply_step && r_active) begin
                if (r_prime) begin
                    // first read issued; empty list resets
                    r_prime <= 1'b0;
                    r_rd    <= r_rd + 1'b1;
                    if (w_cnt_fin == '0) begin
                        r_flags <= '0;
                        r_fg    <= r_def_fg;
                        r_bg    <= r_def_bg;
                    end
                end else if (r_cur >= r_count) begin
                    r_active <= 1'b0;
                end else begin
                    r_rd  <= r_rd + 1'b1;
                    r_cur <= r_cur + 1'b1;
                    case (r_aph)
                        AP_CODE: begin
                            if (w_p == 0) begin
                                r_flags <= '0;
                                r_fg <= r_def_fg;
                                r_bg <= r_def_bg;
                            end else if (w_p == 1) begin
                                r_flags <= (r_flags | 8'h01) & ~8'h02;
                            end else if (w_p == 2) begin
                                r_flags <= (r_flags | 8'h02) & ~8'h01;
                            end else if (w_p >= 3 && w_p <= 5) begin
                                r_flags <= r_flags | (8'h01 << (w_p[2:0] - 3'd1));
                            end else if (w_p >= 7 && w_p <= 9) begin
                                r_flags <= r_flags | (8'h01 << (w_p[3:0] - 4'd2));
                            end else if (w_p == 22) begin
                                r_flags <= r_flags & ~8'h03;
                            end else if (w_p >= 23 && w_p <= 25) begin
                                r_flags <= r_flags & ~(8'h01 << (w_p[4:0] - 5'd21));
                            end else if (w_p >= 27 && w_p <= 29) begin
                                r_flags <= r_flags & ~(8'h01 << (w_p[4:0] - 5'd22));
                            end else if (w_p >= 30 && w_p <= 37) begin
                                r_fg <= basic_color(3'(w_p[5:0] - 6'd30), 1'b0);
                            end else if (w_p >= 90 && w_p <= 97) begin
                                r_fg <= basic_color(3'(w_p[6:0] - 7'd90), 1'b1);
                            end else if (w_p >= 40 && w_p <= 47) begin
                                r_bg <= basic_color(3'(w_p[5:0] - 6'd40), 1'b0);
                            end else if (w_p >= 100 && w_p <= 107) begin
                                r_bg <= basic_color(3'(w_p[6:0] - 7'd100), 1'b1);
                            end else if (w_p == 39) begin
                                r_fg <= r_def_fg;
                            end else if (w_p == 49) begin
                                r_bg <= r_def_bg;
                            end else if (w_p == 38 || w_p == 48) begin
                                r_is_fg <= (w_p == 38);
                                r_aph   <= AP_SEL;
                            end
                        end
                        AP_SEL: begin
                            if (w_p == 5 && r_cur + 1'b1 < r_count) r_aph <= AP_IDX;
                            else if (w_p == 2 && r_cur + 2'd3 < r_count) r_aph <= AP_R;
                            else r_aph <= AP_CODE;
                        end
                        AP_IDX: begin
                            r_aph <= AP_CODE;
                            if (w_p <= PARAM_BITS'(255)) begin
                                if (r_is_fg) r_fg <= indexed_color(w_p[7:0]);
                                else         r_bg <= indexed_color(w_p[7:0]);
                            end
                        end
                        AP_R: begin
                            r_cr <= w_p8;
                            r_aph <= AP_G;
                        end
                        AP_G: begin
                            r_cg <= w_p8;
                            r_aph <= AP_B;
                        end
                        AP_B: begin
                            r_aph <= AP_CODE;
                            if (r_is_fg) r_fg <= {r_cr, r_cg, w_p8};
                            else         r_bg <= {r_cr, r_cg, w_p8};
                        end
                        default: r_aph <= AP_CODE;
                    endcase
                end
            end

            // output register
            if (w_emit) begin
                r_ovalid   <= 1'b1;
                r_ochar    <= i_ctrl.emit_esc ? ESC_BYTE : r_byte;
                r_oattr    <= r_flags;
                r_ofg      <= r_fg;
                r_obg      <= r_bg;
                r_oseg     <= !r_seg_open;
                r_olast    <= i_ctrl.emit_char || (r_byte == ESC_BYTE);
                r_seg_open <= 1'b1;
            end else if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_valid       = r_ovalid;
    assign o_char_code   = r_ochar;
    assign o_attributes  = r_oattr;
    assign o_fg_color    = r_ofg;
    assign o_bg_color    = r_obg;
    assign o_new_segment = r_oseg;
    assign o_last        = r_olast;
endmodule

### src/ansi_sgr_stream_parser.sv
// Path: a text byte is held in r_byte, then emitted from ST_EMIT_CHAR into
// the output register; an ESC then a plain byte leaves two results, the ESC
// first, each as the output register frees. Throughput: 1 byte per cycle
// inside a sequence; a text byte stalls input until the single output
// register is free; final 'm' walks the parameter RAM one entry a cycle.
// Reset: synchronous active low, clears parser, style and defaults.
module ansi_sgr_stream_parser #(
    parameter int MAX_PARAMS = 16,
    parameter int PARAM_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_char_code,
    output logic [7:0]  o_attributes,
    output logic [23:0] o_fg_color,
    output logic [23:0] o_bg_color,
    output logic        o_new_segment,
    output logic        o_last
);
    import asp_pkg::*;

    t_ctrl w_ctrl;
    t_stat w_stat;

    asp_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .i_byte (i_in_byte),
        .i_stat (w_stat),
        .o_stall(o_stall),
        .o_ctrl (w_ctrl)
    );

    asp_datapath #(.MAX_PARAMS(MAX_PARAMS), .PARAM_BITS(PARAM_BITS)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte       (i_in_byte),
        .i_ctrl       (w_ctrl),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_out_stall  (i_stall),
        .o_stat       (w_stat),
        .o_valid      (o_valid),
        .o_char_code  (o_char_code),
        .o_attributes (o_attributes),
        .o_fg_color   (o_fg_color),
        .o_bg_color   (o_bg_color),
        .o_new_segment(o_new_segment),
        .o_last       (o_last)
    );

    // an emit never overwrites a result still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl.emit_esc || w_ctrl.emit_char) |-> !(o_valid && i_stall))
        else $error("result overwritten");

    // after an ESC emit, the result is not the last one unless it is an ESC
    a_esc_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.emit_esc |=> !o_last || (o_char_code == ESC_BYTE))
        else $error("esc last mismatch");

    // no input taken during the walk
    a_walk_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.apply_step |-> o_stall)
        else $error("input taken during apply");
endmodule
